FILE: rtl/core/periodic_callback_timer_table_core_defines.svh
// Assertion macros used by the timer table RTL.
`ifndef PERIODIC_CALLBACK_TIMER_TABLE_CORE_DEFINES_SVH
`define PERIODIC_CALLBACK_TIMER_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pctt_pkg.sv
package pctt_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [2:0] KIND_FIRED    = 3'd0;
    localparam logic [2:0] KIND_ADDED    = 3'd1;
    localparam logic [2:0] KIND_FULL     = 3'd2;
    localparam logic [2:0] KIND_REMOVED  = 3'd3;
    localparam logic [2:0] KIND_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] handler_id;
        logic [15:0] period;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] fired_id;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] countdown;
        logic [15:0] period;
        logic [31:0] handler;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_entry            wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_push;

endpackage

FILE: rtl/core/periodic_callback_timer_table_core.sv
// Periodic handler table. Slots live in one memory with a registered read, and
// occupied slots always form a prefix of it. An add needs no memory read. An
// enabled tick or a remove of a nonzero id walks the occupied slots with one
// memory read per cycle; a tick that fires several handlers also waits whenever
// the output side stalls. One item is worked on at a time; the next is accepted
// once the previous result sits in the output register. The enable register may
// be written at any time the block is idle.
`include "periodic_callback_timer_table_core_defines.svh"

module periodic_callback_timer_table_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pctt_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pctt_pkg::t_out_item  o_out_item
);

    logic                          r_enable;
    logic                          r_out_valid;
    pctt_pkg::t_out_item           r_out_item;
    logic                          out_free;
    pctt_pkg::t_push               push;
    pctt_pkg::t_ram_req            ram_req;
    logic [pctt_pkg::ENTRY_W-1:0]  ram_rdata;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data;
            end
            if (push.valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push.valid) begin
            r_out_item <= push.item;
        end
    end

    pctt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_enable   (r_enable),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_out_free (out_free),
        .o_push     (push),
        .o_ram      (ram_req),
        .i_rdata    (ram_rdata)
    );

    pctt_ram #(
        .WIDTH (pctt_pkg::ENTRY_W),
        .DEPTH (pctt_pkg::SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    `PCTT_ASSERT_NOW(a_push_has_room, i_clk, i_rst_n, push.valid, out_free,
        "result pushed into a full output register")
    `PCTT_ASSERT_NOW(a_no_rw_overlap, i_clk, i_rst_n, ram_req.we && ram_req.re,
        ram_req.waddr != ram_req.raddr, "table read and write hit the same slot")
    `PCTT_ASSERT_NEXT(a_add_busy, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && (i_in_item.op == pctt_pkg::OP_ADD), o_in_stall,
        "add transaction did not hold off the next input")

endmodule

FILE: rtl/core/pctt_ram.sv
module pctt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds while no read is issued.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/pctt_ctrl.sv
module pctt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_enable,
    input  logic                i_in_valid,
    input  pctt_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    input  logic                i_out_free,
    output pctt_pkg::t_push     o_push,
    output pctt_pkg::t_ram_req  o_ram,
    input  pctt_pkg::t_entry    i_rdata
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_RESP  = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    logic [pctt_pkg::CNT_W-1:0]    r_used, n_used;
    logic [pctt_pkg::CNT_W-1:0]    r_idx, n_idx;
    logic                          r_pend, n_pend;
    logic [pctt_pkg::SLOT_W-1:0]   r_pidx, n_pidx;
    logic                          r_is_remove, n_is_remove;
    logic [31:0]                   r_id, n_id;
    logic                          r_found, n_found;
    logic                          r_hold_valid, n_hold_valid;
    logic [31:0]                   r_hold_id, n_hold_id;
    pctt_pkg::t_out_item           r_resp, n_resp;

    logic accept;
    logic fire;
    logic proc_ok;
    logic more;
    logic issue;
    logic done;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // A fire can only proceed if the previously held fire has somewhere to go.
    assign fire    = r_pend && !r_is_remove && (i_rdata.countdown == 16'd0);
    assign proc_ok = !(fire && r_hold_valid && !i_out_free);
    assign more    = (r_idx < r_used);
    assign issue   = more && (!r_pend || proc_ok);
    assign done    = !more && (!r_pend || proc_ok);

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_is_remove  = r_is_remove;
        n_id         = r_id;
        n_found      = r_found;
        n_hold_valid = r_hold_valid;
        n_hold_id    = r_hold_id;
        n_resp       = r_resp;
        o_push       = '0;
        o_ram        = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_id         = i_in_item.handler_id;
                    n_idx        = '0;
                    n_pend       = 1'b0;
                    n_found      = 1'b0;
                    n_hold_valid = 1'b0;
                    case (i_in_item.op)
                        pctt_pkg::OP_TICK: begin
                            if (i_enable) begin
                                n_is_remove = 1'b0;
                                n_state     = S_WALK;
                            end
                        end
                        pctt_pkg::OP_ADD: begin
                            n_resp.fired_id = i_in_item.handler_id;
                            n_resp.last     = 1'b1;
                            if ((i_in_item.handler_id != 32'd0) &&
                                (r_used < pctt_pkg::CNT_W'(pctt_pkg::SLOTS))) begin
                                o_ram.we                = 1'b1;
                                o_ram.waddr             = r_used[pctt_pkg::SLOT_W-1:0];
                                o_ram.wdata.countdown   = 16'd0;
                                o_ram.wdata.period      = i_in_item.period;
                                o_ram.wdata.handler     = i_in_item.handler_id;
                                n_used                  = r_used + pctt_pkg::CNT_W'(1);
                                n_resp.kind             = pctt_pkg::KIND_ADDED;
                            end else begin
                                n_resp.kind = pctt_pkg::KIND_FULL;
                            end
                            n_state = S_RESP;
                        end
                        pctt_pkg::OP_REMOVE: begin
                            if (i_in_item.handler_id == 32'd0) begin
                                n_resp.kind     = pctt_pkg::KIND_NOTFOUND;
                                n_resp.fired_id = i_in_item.handler_id;
                                n_resp.last     = 1'b1;
                                n_state         = S_RESP;
                            end else begin
                                n_is_remove = 1'b1;
                                n_state     = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_WALK: begin
                if (issue) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_idx[pctt_pkg::SLOT_W-1:0];
                    n_idx       = r_idx + pctt_pkg::CNT_W'(1);
                    n_pidx      = r_idx[pctt_pkg::SLOT_W-1:0];
                    n_pend      = 1'b1;
                end else if (r_pend && proc_ok) begin
                    n_pend = 1'b0;
                end

                if (r_pend && proc_ok) begin
                    if (!r_is_remove) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_pidx;
                        o_ram.wdata = i_rdata;
                        if (fire) begin
                            o_ram.wdata.countdown = i_rdata.period;
                            if (r_hold_valid) begin
                                o_push.valid         = 1'b1;
                                o_push.item.kind     = pctt_pkg::KIND_FIRED;
                                o_push.item.fired_id = r_hold_id;
                                o_push.item.last     = 1'b0;
                            end
                            n_hold_valid = 1'b1;
                            n_hold_id    = i_rdata.handler;
                        end else begin
                            o_ram.wdata.countdown = 16'(i_rdata.countdown - 16'd1);
                        end
                    end else if (r_found) begin
                        // Every slot after the match moves down by one.
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_pidx - pctt_pkg::SLOT_W'(1);
                        o_ram.wdata = i_rdata;
                    end else if (i_rdata.handler == r_id) begin
                        n_found = 1'b1;
                    end
                end

                if (done) begin
                    if (r_is_remove) begin
                        n_resp.fired_id = r_id;
                        n_resp.last     = 1'b1;
                        if (n_found) begin
                            n_resp.kind = pctt_pkg::KIND_REMOVED;
                            n_used      = r_used - pctt_pkg::CNT_W'(1);
                        end else begin
                            n_resp.kind = pctt_pkg::KIND_NOTFOUND;
                        end
                        n_state = S_RESP;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end

            S_FLUSH: begin
                // The final fire of a tick is held back until the walk ends.
                if (!r_hold_valid) begin
                    n_state = S_IDLE;
                end else if (i_out_free) begin
                    o_push.valid         = 1'b1;
                    o_push.item.kind     = pctt_pkg::KIND_FIRED;
                    o_push.item.fired_id = r_hold_id;
                    o_push.item.last     = 1'b1;
                    n_hold_valid         = 1'b0;
                    n_state              = S_IDLE;
                end
            end

            S_RESP: begin
                if (i_out_free) begin
                    o_push.valid = 1'b1;
                    o_push.item  = r_resp;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_found      <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_idx        <= n_idx;
            r_pend       <= n_pend;
            r_found      <= n_found;
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx      <= n_pidx;
        r_is_remove <= n_is_remove;
        r_id        <= n_id;
        r_hold_id   <= n_hold_id;
        r_resp      <= n_resp;
    end

endmodule

FILE: bench/tb.sv
module tb;
    import pctt_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 400;
    localparam int PHASES = 6;

    // Tracks the handler table as the block should hold it and queues the results
    // that each accepted input transaction must produce.
    class timer_table_scoreboard;
        bit          tick_en;
        logic [15:0] count_left [SLOTS];
        logic [15:0] reload [SLOTS];
        logic [31:0] owner [SLOTS];
        int          occupied;
        t_out_item   due_q [$];
        int          errors;
        int          checked;
        int          kind_seen [5];
        int          most_fires;

        function new();
            tick_en = 1'b0;
            occupied = 0;
            errors = 0;
            checked = 0;
            most_fires = 0;
            for (int i = 0; i < SLOTS; i++) begin
                count_left[i] = '0;
                reload[i] = '0;
                owner[i] = '0;
            end
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function void push_result(logic [2:0] kind, logic [31:0] id, logic last);
            t_out_item r;
            r.kind = kind;
            r.fired_id = id;
            r.last = last;
            due_q.push_back(r);
        endfunction

        function void note_input(t_in_item it);
            logic [31:0] fired [$];
            int hit;
            hit = -1;
            case (it.op)
                OP_TICK: begin
                    if (tick_en) begin
                        for (int i = 0; i < occupied; i++) begin
                            if (count_left[i] == 16'd0) begin
                                count_left[i] = reload[i];
                                fired.push_back(owner[i]);
                            end else begin
                                count_left[i] = count_left[i] - 16'd1;
                            end
                        end
                        foreach (fired[k])
                            push_result(KIND_FIRED, fired[k], k == fired.size() - 1);
                        if (fired.size() > most_fires) most_fires = fired.size();
                    end
                end
                OP_ADD: begin
                    if (it.handler_id == 32'd0 || occupied >= SLOTS) begin
                        push_result(KIND_FULL, it.handler_id, 1'b1);
                    end else begin
                        count_left[occupied] = 16'd0;
                        reload[occupied] = it.period;
                        owner[occupied] = it.handler_id;
                        occupied++;
                        push_result(KIND_ADDED, it.handler_id, 1'b1);
                    end
                end
                OP_REMOVE: begin
                    if (it.handler_id != 32'd0) begin
                        for (int i = 0; i < occupied && hit < 0; i++) begin
                            if (owner[i] == it.handler_id) hit = i;
                        end
                    end
                    if (hit < 0) begin
                        push_result(KIND_NOTFOUND, it.handler_id, 1'b1);
                    end else begin
                        // Later slots move down so that occupied slots stay a prefix.
                        for (int j = hit; j < occupied - 1; j++) begin
                            count_left[j] = count_left[j + 1];
                            reload[j] = reload[j + 1];
                            owner[j] = owner[j + 1];
                        end
                        occupied--;
                        count_left[occupied] = '0;
                        reload[occupied] = '0;
                        owner[occupied] = '0;
                        push_result(KIND_REMOVED, it.handler_id, 1'b1);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        task report(string what);
            errors++;
            if (errors <= 20) $display("[%0t] ERROR: %s", $time, what);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (got.kind < 3'd5) kind_seen[got.kind]++;
            if (due_q.size() == 0) begin
                report($sformatf("unexpected result kind %0d id %h last %0d",
                                 got.kind, got.fired_id, got.last));
                return;
            end
            want = due_q.pop_front();
            checked++;
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.fired_id !== want.fired_id)
                report($sformatf("fired_id %h, expected %h", got.fired_id, want.fired_id));
            if (got.last !== want.last)
                report($sformatf("last %0d, expected %0d (id %h)", got.last, want.last,
                                 want.fired_id));
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic      i_cfg_data;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    timer_table_scoreboard sb;
    int in_calm = 0;
    int n_ticks = 0;
    int n_adds = 0;
    int n_removes = 0;

    periodic_callback_timer_table_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #4 i_clk = ~i_clk;

    // Output stalls: mostly short bursts, now and then a long one, and calm stretches.
    initial begin : out_stall_gen
        int stall_left;
        int calm_left;
        int r;
        stall_left = 0;
        calm_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_stall = 1'b1;
                stall_left--;
            end else begin
                i_out_stall = 1'b0;
                if (calm_left > 0) begin
                    calm_left--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 3) calm_left = $urandom_range(20, 80);
                    else if (r < 20) stall_left = $urandom_range(1, 3);
                    else if (r < 23) stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_item);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("No transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, sb.due_q.size());
        $display("periodic_callback_timer_table_core: mismatch");
        $finish;
    end

    function automatic int next_gap();
        int r;
        if (in_calm > 0) begin
            in_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            in_calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [31:0] id,
                             input logic [15:0] per);
        int gap;
        gap = next_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_item.op = op;
        i_in_item.handler_id = id;
        i_in_item.period = per;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(i_in_item);
        if (op == OP_TICK) n_ticks++;
        else if (op == OP_ADD) n_adds++;
        else if (op == OP_REMOVE) n_removes++;
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.due_q.size() != 0) @(posedge i_clk);
    endtask

    // A tick may still be walking the table after its last result, so the write
    // waits out a full walk once nothing is due any more.
    task automatic set_enable(input bit value);
        idle_input();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.tick_en = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_random();
        int r;
        int q;
        logic [1:0] op;
        logic [31:0] id;
        logic [15:0] per;
        r = $urandom_range(0, 99);
        if (r < 35) op = OP_TICK;
        else if (r < 65) op = OP_ADD;
        else if (r < 95) op = OP_REMOVE;
        else op = OP_UNUSED;
        if (op == OP_ADD && sb.occupied == SLOTS && $urandom_range(0, 1) == 1) op = OP_REMOVE;
        id = $urandom;
        per = 16'($urandom);
        q = $urandom_range(0, 99);
        if (op == OP_ADD) begin
            // A small id pool makes duplicates and later removes likely.
            if (q < 5) id = '0;
            else if (q < 75) id = $urandom_range(1, 12);
            q = $urandom_range(0, 99);
            if (q < 40) per = 16'($urandom_range(0, 3));
            else if (q < 80) per = 16'($urandom_range(4, 20));
            else if (q < 90) per = 16'hFFFF;
        end else if (op == OP_REMOVE) begin
            if (q < 70 && sb.occupied > 0) id = sb.owner[$urandom_range(0, sb.occupied - 1)];
            else if (q < 80) id = '0;
            else if (q < 92) id = $urandom_range(1, 12);
        end
        send_item(op, id, per);
    endtask

    initial begin
        int done_here;
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, starting disabled.
        set_enable(1'b0);
        send_item(OP_TICK, 32'hA5A5_5A5A, 16'h1234);
        send_item(OP_ADD, 32'h0, 16'd5);
        send_item(OP_REMOVE, 32'h0, 16'd0);
        send_item(OP_REMOVE, 32'h0000_0077, 16'd0);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF);
        set_enable(1'b1);
        send_item(OP_TICK, 32'h0, 16'd0);
        send_item(OP_TICK, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_ADD, 32'h1, 16'd0);
        send_item(OP_ADD, 32'h1, 16'd0);
        send_item(OP_TICK, 32'h0, 16'd0);
        send_item(OP_REMOVE, 32'h1, 16'd0);
        for (int k = 0; k < SLOTS - 2; k++) send_item(OP_ADD, 32'h100 + k, 16'd0);
        send_item(OP_ADD, 32'h200, 16'd0);
        send_item(OP_TICK, 32'h0, 16'd0);

        // Random part, with the enable setting changed between phases.
        for (int phase = 0; phase < PHASES; phase++) begin
            set_enable((phase == 1 || phase == 4) ? 1'b0 : 1'b1);
            done_here = 0;
            while (done_here < RANDOM_ITEMS / PHASES) begin
                send_random();
                done_here++;
            end
        end

        idle_input();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d ticks, %0d adds, %0d removes; checked %0d results,",
                 n_ticks, n_adds, n_removes, sb.checked);
        $display("up to %0d fires per tick; kinds: fired %0d, added %0d, full %0d, %s",
                 sb.most_fires, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2],
                 $sformatf("removed %0d, not found %0d", sb.kind_seen[3], sb.kind_seen[4]));
        if (sb.errors == 0)
            $display("periodic_callback_timer_table_core: match");
        else
            $display("periodic_callback_timer_table_core: mismatch");
        $finish;
    end
endmodule
